FILE: rtl/core/drt_pkg.sv
// Shared types, register indexes and period helpers for the divider and reload timer.
package drt_pkg;

  localparam int unsigned TickClocks = 4;
  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth = 8;

  localparam logic [CfgIndexWidth-1:0] RegTimerEnable = 2'd0;
  localparam logic [CfgIndexWidth-1:0] RegClockSelect = 2'd1;
  localparam logic [CfgIndexWidth-1:0] RegReloadValue = 2'd2;

  typedef enum logic [1:0] {
    SEL_1024 = 2'd0,
    SEL_16   = 2'd1,
    SEL_64   = 2'd2,
    SEL_256  = 2'd3
  } clock_sel_t;

  typedef struct packed {
    logic [7:0] divider_prescale;
    logic [7:0] divider_count;
    logic [9:0] timer_prescale;
    logic [7:0] timer_count;
  } timer_state_t;

  typedef struct packed {
    logic       timer_enable;
    clock_sel_t clock_select;
    logic [7:0] reload_value;
  } timer_cfg_t;

  // Mask that keeps the remainder below the selected period.
  function automatic logic [9:0] period_mask(input clock_sel_t sel);
    logic [9:0] mask;
    case (sel)
      SEL_1024: mask = 10'h3FF;
      SEL_16:   mask = 10'h00F;
      SEL_64:   mask = 10'h03F;
      SEL_256:  mask = 10'h0FF;
      default:  mask = 10'h3FF;
    endcase
    return mask;
  endfunction

  // Right shift that divides by the selected period.
  function automatic logic [3:0] period_shift(input clock_sel_t sel);
    logic [3:0] shift;
    case (sel)
      SEL_1024: shift = 4'd10;
      SEL_16:   shift = 4'd4;
      SEL_64:   shift = 4'd6;
      SEL_256:  shift = 4'd8;
      default:  shift = 4'd10;
    endcase
    return shift;
  endfunction

endpackage

FILE: rtl/core/drt_step.sv
// Next-state logic of the timer for one tick or load transaction.
module drt_step (
  input  drt_pkg::timer_state_t state,
  input  drt_pkg::timer_cfg_t   cfg,
  input  logic                  kind,
  input  logic [7:0]            load_value,
  output drt_pkg::timer_state_t state_next,
  output logic                  irq
);
  import drt_pkg::*;

  logic [8:0]  div_sum;
  logic [10:0] acc;
  logic [10:0] inc;
  logic [9:0]  rem;
  logic [8:0]  count_sum;
  logic [9:0]  sum_mod;
  logic [7:0]  reload_sum;

  always_comb begin
    div_sum    = {1'b0, state.divider_prescale} + 9'(TickClocks);
    acc        = {1'b0, state.timer_prescale} + 11'(TickClocks);
    inc        = acc >> period_shift(cfg.clock_select);
    rem        = acc[9:0] & period_mask(cfg.clock_select);
    // The quotient never exceeds 64, so seven bits carry it into the sum.
    count_sum  = {1'b0, state.timer_count} + {2'b00, inc[6:0]};
    sum_mod    = {1'b0, count_sum} & period_mask(cfg.clock_select);
    reload_sum = cfg.reload_value + sum_mod[7:0];

    state_next = state;
    irq        = 1'b0;
    if (kind) begin
      state_next.timer_count = load_value;
    end else begin
      state_next.divider_prescale = div_sum[7:0];
      if (div_sum[8]) begin
        state_next.divider_count = state.divider_count + 8'd1;
      end
      if (cfg.timer_enable) begin
        state_next.timer_prescale = rem;
        if (count_sum[8]) begin
          state_next.timer_count = reload_sum;
          irq                    = 1'b1;
        end else begin
          state_next.timer_count = count_sum[7:0];
        end
      end
    end
  end

endmodule

FILE: rtl/core/divider_and_reload_timer.sv
// Top level of the divider and reload timer with its handshake and configuration port.
//
// Input channel: in_valid/in_stall carry one transaction with kind and
// load_value. A tick transaction (kind 0) advances the prescalers by
// TickClocks; a load transaction (kind 1) writes the counter directly.
// Output channel: out_valid/out_stall carry one result per input
// transaction: divider_value, count_value and overflow_irq.
// Configuration: cfg_write_enable with cfg_index and cfg_data writes
// timer_enable (0), clock_select (1) or reload_value (2); other indexes
// are ignored. Write only while no transaction is in flight.
// The result is registered: a transaction accepted in one cycle shows
// its result in the next. Throughput is one transaction per cycle while
// the receiver does not stall, set by the single state update between
// the state registers and the result register. While the receiver stalls,
// the result register holds and in_stall is raised until the result is taken.
// Reset clears all counters, prescalers and configuration registers and
// empties the result register.
module divider_and_reload_timer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write_enable,
  input  logic [drt_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  logic [drt_pkg::CfgDataWidth-1:0]   cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               kind,
  input  logic [7:0]                         load_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [7:0]                         divider_value,
  output logic [7:0]                         count_value,
  output logic                               overflow_irq
);
  import drt_pkg::*;

  timer_state_t state;
  timer_state_t state_next;
  timer_cfg_t   cfg;
  logic         irq_next;
  logic         accept;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  drt_step u_step (
    .state      (state),
    .cfg        (cfg),
    .kind       (kind),
    .load_value (load_value),
    .state_next (state_next),
    .irq        (irq_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg       <= '0;
      state     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write_enable) begin
        case (cfg_index)
          RegTimerEnable: cfg.timer_enable <= cfg_data[0];
          RegClockSelect: cfg.clock_select <= clock_sel_t'(cfg_data[1:0]);
          RegReloadValue: cfg.reload_value <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload needs no reset; it is loaded with every transaction.
  always_ff @(posedge clk) begin
    if (accept) begin
      divider_value <= state_next.divider_count;
      count_value   <= state_next.timer_count;
      overflow_irq  <= irq_next;
    end
  end

endmodule
